// ===== src/mi4_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and operand tables for the 4x4 matrix inverse
// no dependencies
package mi4_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 67;
    localparam int Q_W    = 34;
    localparam int DSR_W  = ACC_W + Q_W - 1;

    typedef enum logic [1:0] {
        DEST_SD  = 2'd0,
        DEST_ADJ = 2'd1,
        DEST_DET = 2'd2
    } t_dest;

    typedef enum logic [1:0] {
        B_M   = 2'd0,
        B_SD  = 2'd1,
        B_ADJ = 2'd2
    } t_bsrc;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic       neg;
        t_dest      dest;
        logic [4:0] dst_addr;
        logic [3:0] a_addr;
        t_bsrc      b_sel;
        logic [4:0] b_addr;
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] adj_raddr;
        logic       ld_we;
        logic [3:0] ld_addr;
        logic       clr_ovf;
        logic       div_ld;
        logic       div_step;
        logic       div_wr;
        logic [3:0] idx;
        logic       out_wr;
    } t_ctrl;

    typedef struct packed {
        logic sing;
        logic out_free;
    } t_stat;

    // {a, b, c, d}: sub-determinant = m[a]*m[b] - m[c]*m[d]
    function automatic logic [15:0] sub_row(input logic [4:0] idx);
        logic [15:0] r;
        r = 16'h0;
        case (idx)
            5'd0:    r = {4'd10, 4'd15, 4'd14, 4'd11};
            5'd1:    r = {4'd6,  4'd15, 4'd14, 4'd7};
            5'd2:    r = {4'd6,  4'd11, 4'd10, 4'd7};
            5'd3:    r = {4'd9,  4'd15, 4'd13, 4'd11};
            5'd4:    r = {4'd5,  4'd15, 4'd13, 4'd7};
            5'd5:    r = {4'd5,  4'd11, 4'd9,  4'd7};
            5'd6:    r = {4'd9,  4'd14, 4'd13, 4'd10};
            5'd7:    r = {4'd5,  4'd14, 4'd13, 4'd6};
            5'd8:    r = {4'd5,  4'd10, 4'd9,  4'd6};
            5'd9:    r = {4'd8,  4'd15, 4'd12, 4'd11};
            5'd10:   r = {4'd4,  4'd15, 4'd12, 4'd7};
            5'd11:   r = {4'd4,  4'd11, 4'd8,  4'd7};
            5'd12:   r = {4'd8,  4'd14, 4'd12, 4'd10};
            5'd13:   r = {4'd4,  4'd14, 4'd12, 4'd6};
            5'd14:   r = {4'd4,  4'd10, 4'd8,  4'd6};
            5'd15:   r = {4'd8,  4'd13, 4'd12, 4'd9};
            5'd16:   r = {4'd4,  4'd13, 4'd12, 4'd5};
            5'd17:   r = {4'd4,  4'd9,  4'd8,  4'd5};
            default: r = 16'h0;
        endcase
        return r;
    endfunction

    // {v0, f0, v1, f1, v2, f2} per adjugate column, one nibble each
    function automatic logic [23:0] adj_row(input logic [1:0] c);
        logic [23:0] r;
        r = 24'h0;
        case (c)
            2'd0:    r = {4'd1, 4'd0, 4'd2, 4'd1, 4'd3, 4'd2};
            2'd1:    r = {4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd4};
            2'd2:    r = {4'd0, 4'd1, 4'd1, 4'd3, 4'd3, 4'd5};
            default: r = {4'd0, 4'd2, 4'd1, 4'd4, 4'd2, 4'd5};
        endcase
        return r;
    endfunction

endpackage

// ===== src/mi4_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for loading, multiply-accumulate phases, division and readout
// depends on mi4_pkg
module mi4_ctrl
    import mi4_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_SUB  = 11'b00000000010,
        S_WSUB = 11'b00000000100,
        S_ADJ  = 11'b00000001000,
        S_WADJ = 11'b00000010000,
        S_DET  = 11'b00000100000,
        S_WDET = 11'b00001000000,
        S_DRD  = 11'b00010000000,
        S_DLD  = 11'b00100000000,
        S_DRUN = 11'b01000000000,
        S_ORD  = 11'b10000000000
    } t_state;

    t_state      r_state, n_state;
    logic        r_owr, n_owr;
    logic [4:0]  r_idx, n_idx;
    logic [1:0]  r_term, n_term;
    logic [5:0]  r_cnt, n_cnt;
    logic [3:0]  r_load_cnt, n_load_cnt;
    logic        r_full, n_full;
    logic        accept;
    logic [15:0] srow;
    logic [23:0] arow;
    logic [3:0]  av, af;
    logic [1:0]  c, k;
    logic        dwr;

    assign o_stall = r_full;
    assign accept  = i_valid & ~r_full;
    assign srow    = sub_row(r_idx);
    assign c       = r_idx[3:2];
    assign k       = r_idx[1:0];
    assign arow    = adj_row(c);

    always_comb begin
        case (r_term)
            2'd0:    begin av = arow[23:20]; af = arow[19:16]; end
            2'd1:    begin av = arow[15:12]; af = arow[11:8];  end
            default: begin av = arow[7:4];   af = arow[3:0];   end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_owr      = r_owr;
        n_idx      = r_idx;
        n_term     = r_term;
        n_cnt      = r_cnt;
        n_load_cnt = r_load_cnt;
        n_full     = r_full;
        dwr        = 1'b0;
        o_ctrl     = '0;
        o_ctrl.cmd.dest  = DEST_SD;
        o_ctrl.cmd.b_sel = B_M;
        o_ctrl.ld_we     = accept;
        o_ctrl.ld_addr   = r_load_cnt;
        o_ctrl.idx       = r_idx[3:0];
        o_ctrl.adj_raddr = r_idx[3:0];

        if (accept) begin
            if (r_load_cnt == 4'd15) begin
                n_load_cnt = 4'd0;
                n_full     = 1'b1;
            end else begin
                n_load_cnt = r_load_cnt + 4'd1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (r_full) begin
                    o_ctrl.clr_ovf = 1'b1;
                    n_state = S_SUB;
                    n_idx   = 5'd0;
                    n_term  = 2'd0;
                end
            end
            S_SUB: begin
                o_ctrl.cmd.valid    = 1'b1;
                o_ctrl.cmd.first    = (r_term == 2'd0);
                o_ctrl.cmd.last     = (r_term == 2'd1);
                o_ctrl.cmd.neg      = r_term[0];
                o_ctrl.cmd.dest     = DEST_SD;
                o_ctrl.cmd.dst_addr = r_idx;
                o_ctrl.cmd.b_sel    = B_M;
                o_ctrl.cmd.a_addr   = r_term[0] ? srow[7:4] : srow[15:12];
                o_ctrl.cmd.b_addr   = {1'b0, (r_term[0] ? srow[3:0] : srow[11:8])};
                if (r_term == 2'd1) begin
                    n_term = 2'd0;
                    if (r_idx == 5'd17) begin
                        n_state = S_WSUB;
                        n_cnt   = 6'd0;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_WSUB: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd3) begin
                    n_state = S_ADJ;
                    n_idx   = 5'd0;
                    n_term  = 2'd0;
                end
            end
            S_ADJ: begin
                o_ctrl.cmd.valid    = 1'b1;
                o_ctrl.cmd.first    = (r_term == 2'd0);
                o_ctrl.cmd.last     = (r_term == 2'd2);
                o_ctrl.cmd.neg      = (r_term == 2'd1) ^ (c[0] ^ k[0]);
                o_ctrl.cmd.dest     = DEST_ADJ;
                o_ctrl.cmd.dst_addr = r_idx;
                o_ctrl.cmd.b_sel    = B_SD;
                o_ctrl.cmd.a_addr   = (k == 2'd0) ? (av + 4'd4) : av;
                o_ctrl.cmd.b_addr   = (5'(af) << 1) + 5'(af)
                                    + ((k == 2'd0) ? 5'd0 : (5'(k) - 5'd1));
                if (r_term == 2'd2) begin
                    n_term = 2'd0;
                    if (r_idx == 5'd15) begin
                        n_state = S_WADJ;
                        n_cnt   = 6'd0;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_WADJ: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd3) begin
                    n_state = S_DET;
                    n_term  = 2'd0;
                end
            end
            S_DET: begin
                o_ctrl.cmd.valid    = 1'b1;
                o_ctrl.cmd.first    = (r_term == 2'd0);
                o_ctrl.cmd.last     = (r_term == 2'd3);
                o_ctrl.cmd.neg      = 1'b0;
                o_ctrl.cmd.dest     = DEST_DET;
                o_ctrl.cmd.b_sel    = B_ADJ;
                o_ctrl.cmd.a_addr   = {2'b00, r_term};
                o_ctrl.cmd.b_addr   = {1'b0, r_term, 2'b00};
                o_ctrl.adj_raddr    = {r_term, 2'b00};
                if (r_term == 2'd3) begin
                    n_state = S_WDET;
                    n_cnt   = 6'd0;
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_WDET: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd3) begin
                    // matrix store no longer needed: open it for the next matrix
                    n_full  = 1'b0;
                    n_idx   = 5'd0;
                    n_owr   = 1'b0;
                    n_state = i_stat.sing ? S_ORD : S_DRD;
                end
            end
            S_DRD: begin
                n_state = S_DLD;
            end
            S_DLD: begin
                o_ctrl.div_ld = 1'b1;
                n_cnt   = 6'd0;
                n_state = S_DRUN;
            end
            S_DRUN: begin
                if (r_cnt == 6'(Q_W)) begin
                    dwr = 1'b1;
                    o_ctrl.div_wr = 1'b1;
                    if (r_idx == 5'd15) begin
                        n_idx   = 5'd0;
                        n_owr   = 1'b0;
                        n_state = S_ORD;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        n_state = S_DRD;
                    end
                end else begin
                    o_ctrl.div_step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ORD: begin
                if (!r_owr) begin
                    n_owr = 1'b1;
                end else if (i_stat.out_free) begin
                    o_ctrl.out_wr = 1'b1;
                    n_owr = 1'b0;
                    if (r_idx == 5'd15) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (dwr) begin
            o_ctrl.idx = r_idx[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_owr      <= 1'b0;
            r_idx      <= 5'd0;
            r_term     <= 2'd0;
            r_cnt      <= 6'd0;
            r_load_cnt <= 4'd0;
            r_full     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_owr      <= n_owr;
            r_idx      <= n_idx;
            r_term     <= n_term;
            r_cnt      <= n_cnt;
            r_load_cnt <= n_load_cnt;
            r_full     <= n_full;
        end
    end

endmodule

// ===== src/mi4_dp.sv =====
`timescale 1ns / 1ps
// datapath: element stores, multiply-accumulate pipeline, divider, output register
// depends on mi4_pkg
module mi4_dp
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    output t_stat                    o_stat,
    input  logic signed [DATA_W-1:0] i_elem_value,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_inv_value,
    output logic [3:0]               o_inv_index,
    output logic                     o_last_elem,
    output logic                     o_singular,
    output logic                     o_overflow
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic [DATA_W-1:0] r_mem_m   [16];
    logic [DATA_W-1:0] r_mem_sd  [18];
    logic [DATA_W-1:0] r_mem_adj [16];

    logic signed [DATA_W-1:0] r_ma, r_mb, r_sd_rd, r_adj_rd;
    t_cmd                     r_cmd1, r_cmd2, r_cmd3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ACC_W-1:0]  r_det;
    logic                     r_ovf;
    logic [ACC_W-1:0]         r_rem;
    logic [DSR_W-1:0]         r_dsr;
    logic [Q_W-1:0]           r_q;
    logic                     r_qneg;
    logic                     r_out_valid;

    logic signed [DATA_W-1:0] opb;
    logic signed [ACC_W-1:0]  prod_ext, rnd;
    logic                     rnd_sat;
    logic [DATA_W-1:0]        rnd_val;
    logic [ACC_W-1:0]         nd;
    logic [DATA_W-1:0]        na;
    logic                     ge;
    logic                     q_sat;
    logic [DATA_W-1:0]        q_val;
    logic                     wr_mac;

    assign o_stat.sing     = (r_det == '0);
    assign o_stat.out_free = ~r_out_valid | ~i_stall;
    assign o_valid         = r_out_valid;

    // operand b selection for the multiply
    always_comb begin
        case (r_cmd1.b_sel)
            B_SD:    opb = r_sd_rd;
            B_ADJ:   opb = r_adj_rd;
            default: opb = r_mb;
        endcase
    end

    assign prod_ext = ACC_W'(r_prod);
    assign n_acc    = (r_cmd2.first ? '0 : r_acc) + (r_cmd2.neg ? -prod_ext : prod_ext);

    // round to nearest, ties up, then clamp to 32 bits
    assign rnd     = (r_acc + HALF) >>> FRAC_BITS;
    assign rnd_sat = (rnd > ACC_W'(64'sh7FFFFFFF)) || (rnd < -(ACC_W'(64'sh80000000)));
    assign rnd_val = rnd_sat ? (rnd[ACC_W-1] ? 32'h80000000 : 32'h7FFFFFFF)
                             : rnd[DATA_W-1:0];
    assign wr_mac  = r_cmd3.valid & r_cmd3.last;

    // divider operands and one restoring step
    assign nd = r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
    assign na = r_adj_rd[DATA_W-1] ? (~r_adj_rd + 32'd1) : r_adj_rd;
    assign ge = (DSR_W'(r_rem) >= r_dsr);

    always_comb begin
        if (r_qneg) begin
            q_sat = (r_q[Q_W-1:DATA_W] != '0) || (r_q[DATA_W-1] && (r_q[DATA_W-2:0] != '0));
            q_val = q_sat ? 32'h80000000 : (~r_q[DATA_W-1:0] + 32'd1);
        end else begin
            q_sat = (r_q[Q_W-1:DATA_W-1] != '0);
            q_val = q_sat ? 32'h7FFFFFFF : r_q[DATA_W-1:0];
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_we) begin
            r_mem_m[i_ctrl.ld_addr] <= i_elem_value;
        end
        if (wr_mac && r_cmd3.dest == DEST_SD) begin
            r_mem_sd[r_cmd3.dst_addr] <= rnd_val;
        end
        if (wr_mac && r_cmd3.dest == DEST_ADJ) begin
            r_mem_adj[r_cmd3.dst_addr[3:0]] <= rnd_val;
        end else if (i_ctrl.div_wr) begin
            r_mem_adj[i_ctrl.idx] <= q_val;
        end
        r_ma     <= r_mem_m[i_ctrl.cmd.a_addr];
        r_mb     <= r_mem_m[i_ctrl.cmd.b_addr[3:0]];
        r_sd_rd  <= r_mem_sd[i_ctrl.cmd.b_addr];
        r_adj_rd <= r_mem_adj[i_ctrl.adj_raddr];
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * opb;
        r_acc  <= n_acc;
        if (wr_mac && r_cmd3.dest == DEST_DET) begin
            r_det <= rnd;
        end
        if (i_ctrl.div_ld) begin
            r_rem  <= (ACC_W'(na) << FRAC_BITS) + (nd >> 1);
            r_dsr  <= DSR_W'(nd) << (Q_W - 1);
            r_q    <= '0;
            r_qneg <= r_adj_rd[DATA_W-1] ^ r_det[ACC_W-1];
        end else if (i_ctrl.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr[ACC_W-1:0];
            end
            r_q   <= {r_q[Q_W-2:0], ge};
            r_dsr <= r_dsr >> 1;
        end
        if (i_ctrl.out_wr) begin
            o_inv_value <= o_stat.sing ? '0 : r_adj_rd;
            o_inv_index <= i_ctrl.idx;
            o_last_elem <= (i_ctrl.idx == 4'd15);
            o_singular  <= o_stat.sing;
            o_overflow  <= r_ovf;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd1      <= '0;
            r_cmd2      <= '0;
            r_cmd3      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd1 <= i_ctrl.cmd;
            r_cmd2 <= r_cmd1;
            r_cmd3 <= r_cmd2;
            if (i_ctrl.clr_ovf) begin
                r_ovf <= 1'b0;
            end else if ((wr_mac && r_cmd3.dest != DEST_DET && rnd_sat)
                         || (i_ctrl.div_wr && q_sat)) begin
                r_ovf <= 1'b1;
            end
            if (i_ctrl.out_wr) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/matrix4_inverse_top.sv =====
`timescale 1ns / 1ps
// top level of the 4x4 fixed-point matrix inverse
// depends on mi4_pkg, mi4_ctrl, mi4_dp

// Takes the sixteen elements of a 4x4 signed fixed-point matrix (FRAC_BITS
// fraction bits) in column-major order, one item each, then emits sixteen
// inverse items in column-major order with index, last, singular and overflow
// marks. One shared 32x32 multiplier with a wide accumulator forms the 18
// sub-determinants (36 products), the adjugate (48 products) and the
// determinant (4 products); a one-bit-per-cycle restoring divider (34 steps)
// then forms each inverse element. A matrix passes through the multiply work
// (88 products, with a pipeline drain after each of the three phases), then
// the divider for each of the sixteen elements, then the readout, in which
// each item is read and then written to the output register once it is free;
// a singular matrix skips the divider. Loading the next matrix overlaps the
// division and readout of the current one; input stalls while a loaded
// matrix waits for the multiply phases.
module matrix4_inverse_top
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input item channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_elem_value,
    // result item channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_inv_value,
    output logic [3:0]               o_inv_index,
    output logic                     o_last_elem,
    output logic                     o_singular,
    output logic                     o_overflow
);

    t_ctrl ctrl;
    t_stat stat;

    // sequencer: load counter, phase state machine, operand addressing
    mi4_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // stores, multiply-accumulate pipeline, divider and output register
    mi4_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_elem_value (i_elem_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_inv_value  (o_inv_value),
        .o_inv_index  (o_inv_index),
        .o_last_elem  (o_last_elem),
        .o_singular   (o_singular),
        .o_overflow   (o_overflow)
    );

endmodule
